>>> hdl/dtcs_pkg.sv
// Shared constants, codes and the switching table of the DTC switching block.
// Used by the root unit, the top level and the testbench; depends on nothing.
`default_nettype none

package dtcs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 32;
   localparam int MUL_A_W  = 36;
   localparam int MUL_B_W  = 25;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ROOT_IN_W  = 36;
   localparam int ROOT_W     = 19;
   localparam int ROOT_STEPS = 19;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [16:0] SIN60_Q16 = 17'd56756;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_RESISTANCE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLUX_CMD   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_CMD = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POLE_PAIRS = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_EMF   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_L_DIFF     = 4'd7;

   // Comparator levels.
   localparam logic       FLUX_RAISE = 1'b0;
   localparam logic       FLUX_LOWER = 1'b1;
   localparam logic [1:0] TQ_RAISE   = 2'd0;
   localparam logic [1:0] TQ_HOLD    = 2'd1;
   localparam logic [1:0] TQ_LOWER   = 2'd2;

   // Active voltage vectors by angle; 0 and 7 are the zero vectors.
   localparam logic [2:0] VEC_P0   = 3'd1;
   localparam logic [2:0] VEC_P60  = 3'd2;
   localparam logic [2:0] VEC_P120 = 3'd3;
   localparam logic [2:0] VEC_P180 = 3'd4;
   localparam logic [2:0] VEC_P240 = 3'd5;
   localparam logic [2:0] VEC_P300 = 3'd6;

   localparam logic [2:0] VEC_TABLE [6][6] = '{
      '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1},
      '{3'd7, 3'd0, 3'd7, 3'd0, 3'd7, 3'd0},
      '{3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
      '{3'd3, 3'd4, 3'd5, 3'd6, 3'd1, 3'd2},
      '{3'd0, 3'd7, 3'd0, 3'd7, 3'd0, 3'd7},
      '{3'd5, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4}};

   function automatic logic [2:0] vec_lookup(input logic [2:0] row, input logic [2:0] sec);
      return VEC_TABLE[row][sec];
   endfunction

endpackage

`default_nettype wire

>>> hdl/dtcs_isqrt.sv
// Iterative integer square root, two bits of the radicand per cycle.
// Depends on dtcs_pkg for its widths.
`default_nettype none

module dtcs_isqrt (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [dtcs_pkg::ROOT_IN_W-1:0]   radicand,
   output logic                                  busy,
   output logic      [dtcs_pkg::ROOT_W-1:0]      root
);

   localparam int RW = dtcs_pkg::ROOT_IN_W + 1;

   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] res_ff, res_in;
   logic [4:0]    step_ff, step_in;
   logic          busy_ff, busy_in;
   logic [RW-1:0] bit_val, trial;

   always_comb begin
      bit_val = RW'(1) << {step_ff, 1'b0};
      trial   = res_ff + bit_val;
      rem_in  = rem_ff;
      res_in  = res_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = RW'(radicand);
         res_in  = '0;
         step_in = 5'(dtcs_pkg::ROOT_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_val;
         end else begin
            res_in = res_ff >> 1;
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      step_ff <= step_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[dtcs_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

>>> hdl/direct_torque_control_switching_top.sv
// Direct torque control switching block: flux integration, torque estimate,
// hysteresis comparators, sector search and vector choice.
// One sample at a time: no new sample is taken until the result word of the
// last one is in the output register. The time per sample is set by the 19-step
// square root of the flux magnitude behind the shared multiplier steps.
// Reset (synchronous) restores the register defaults and clears the flux integrators
// and both comparator states.
// Depends on dtcs_pkg and dtcs_isqrt.
`default_nettype none

module direct_torque_control_switching_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [15:0]                  req_u_alpha,
   input  wire logic signed [15:0]                  req_u_beta,
   input  wire logic signed [15:0]                  req_i_alpha,
   input  wire logic signed [15:0]                  req_i_beta,
   input  wire logic signed [15:0]                  req_i_d,
   input  wire logic signed [15:0]                  req_i_q,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [2:0]                   rsp_vector_index,
   output logic signed      [15:0]                  rsp_drive_alpha,
   output logic signed      [15:0]                  rsp_drive_beta,
   output logic signed      [15:0]                  rsp_torque_estimate,
   output logic             [15:0]                  rsp_flux_estimate,
   output logic             [2:0]                   rsp_sector,
   output logic                                     rsp_flux_level,
   output logic             [1:0]                   rsp_torque_level,
   input  wire logic                                csr_we,
   input  wire logic        [dtcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [dtcs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = dtcs_pkg::ACC_W;
   localparam int PW = dtcs_pkg::PROD_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
      ST_M8, ST_M9, ST_M10, ST_M11, ST_M12, ST_WAIT, ST_FIN
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic        [15:0] res_ff;
   logic        [23:0] per_ff;
   logic        [15:0] fcmd_ff;
   logic signed [15:0] tcmd_ff;
   logic        [14:0] amp_ff;
   logic        [4:0]  pp_ff;
   logic        [15:0] kemf_ff;
   logic signed [15:0] ldiff_ff;

   // Sample words.
   logic signed [15:0] ua_ff, ub_ff, ia_ff, ib_ff, id_ff, iq_ff;

   // Datapath registers.
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [34:0]   da_ff, da_in, db_ff, db_in;
   logic signed [AW-1:0] acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic        [34:0]   xx_ff, xx_in, yy_ff, yy_in;
   logic signed [36:0]   tk_ff, tk_in;
   logic signed [49:0]   s_ff, s_in;
   logic        [39:0]   band_ff, band_in;
   logic signed [40:0]   tband_ff, tband_in;
   logic        [14:0]   high_ff, high_in;
   logic signed [55:0]   t36_ff, t36_in;
   logic        [2:0]    pp_cnt_ff, pp_cnt_in;
   logic                 pp_busy_ff, pp_busy_in;
   logic                 flux_st_ff, flux_st_in;
   logic        [1:0]    tq_st_ff, tq_st_in;

   // Result word.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic        [2:0]    vec_ff, vec_in;
   logic signed [15:0]   dra_ff, dra_in, drb_ff, drb_in;
   logic signed [15:0]   tq_ff, tq_in;
   logic        [15:0]   flux_ff, flux_in;
   logic        [2:0]    sec_ff, sec_in;
   logic                 fl_ff, fl_in;
   logic        [1:0]    tl_ff, tl_in;

   logic signed [dtcs_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dtcs_pkg::MUL_B_W-1:0] mul_b;
   logic signed [17:0]   a14, b14;
   logic                 root_busy;
   logic [dtcs_pkg::ROOT_W-1:0] root;
   logic                 root_start;
   logic [35:0]          root_arg;

   // Finishing logic.
   logic signed [45:0] ferr, fband;
   logic signed [57:0] terr, tband;
   logic        [1:0]  tl;
   logic        [2:0]  sec, row, vec;
   logic        [36:0] xx3;
   logic        [14:0] half;
   logic signed [27:0] t_shift;

   localparam logic signed [45:0] ACC_MAX = (46'sd1 <<< (AW - 1)) - 46'sd1;
   localparam logic signed [45:0] ACC_MIN = -(46'sd1 <<< (AW - 1));

   function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW-1:0] acc,
                                                    input logic signed [PW-1:0] prod);
      logic signed [45:0] sum;
      sum = 46'(acc) + 46'($signed(prod[PW-1:16]));
      if (sum > ACC_MAX) begin
         return ACC_MAX[AW-1:0];
      end else if (sum < ACC_MIN) begin
         return ACC_MIN[AW-1:0];
      end
      return sum[AW-1:0];
   endfunction

   assign a14 = $signed(acc_a_ff[AW-1:AW-18]);
   assign b14 = $signed(acc_b_ff[AW-1:AW-18]);

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M0:  begin mul_a = 36'(ia_ff);    mul_b = 25'(res_ff);  end
         ST_M1:  begin mul_a = 36'(ib_ff);    mul_b = 25'(res_ff);  end
         ST_M2:  begin mul_a = 36'(da_ff);    mul_b = 25'(per_ff);  end
         ST_M3:  begin mul_a = 36'(db_ff);    mul_b = 25'(per_ff);  end
         ST_M4:  begin mul_a = 36'(a14);      mul_b = 25'(a14);     end
         ST_M5:  begin mul_a = 36'(b14);      mul_b = 25'(b14);     end
         ST_M6:  begin mul_a = 36'(iq_ff);    mul_b = 25'(kemf_ff); end
         ST_M7:  begin mul_a = 36'(ldiff_ff); mul_b = 25'(id_ff);   end
         ST_M8:  begin mul_a = $signed(prod_ff[35:0]); mul_b = 25'(iq_ff); end
         ST_M9:  begin mul_a = 36'(fcmd_ff);  mul_b = 25'(per_ff);  end
         ST_M10: begin mul_a = 36'(tcmd_ff);  mul_b = 25'(per_ff);  end
         ST_M11: begin mul_a = 36'(amp_ff);   mul_b = 25'(dtcs_pkg::SIN60_Q16); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in    = PW'(mul_a) * PW'(mul_b);
   assign root_start = (state_ff == ST_M7);
   assign root_arg   = 36'(xx_ff) + 36'(yy_ff);

   dtcs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_arg),
      .busy     (root_busy),
      .root     (root)
   );

   // Comparators, sector and vector for the result word.
   always_comb begin
      ferr  = 46'($signed({1'b0, fcmd_ff}) - $signed({1'b0, root})) <<< 24;
      fband = 46'($signed({1'b0, band_ff}));
      flux_st_in = flux_st_ff;
      if (ferr >= fband) begin
         flux_st_in = dtcs_pkg::FLUX_RAISE;
      end
      if (ferr <= -fband) begin
         flux_st_in = dtcs_pkg::FLUX_LOWER;
      end

      terr  = (58'(tcmd_ff) <<< 28) - 58'(t36_ff);
      tband = 58'(tband_ff) <<< 4;
      tl = tq_st_ff;
      if (terr > tband) begin
         tl = dtcs_pkg::TQ_RAISE;
      end
      if (terr < -tband) begin
         tl = dtcs_pkg::TQ_LOWER;
      end
      if (terr == 58'sd0) begin
         tl = dtcs_pkg::TQ_HOLD;
      end
      if (-tband <= terr && terr < 58'sd0 && tq_st_ff == dtcs_pkg::TQ_RAISE) begin
         tl = dtcs_pkg::TQ_HOLD;
      end
      if (-tband <= terr && terr < 58'sd0 && tq_st_ff == dtcs_pkg::TQ_LOWER) begin
         tl = dtcs_pkg::TQ_LOWER;
      end
      if (58'sd0 < terr && terr <= tband && tq_st_ff == dtcs_pkg::TQ_RAISE) begin
         tl = dtcs_pkg::TQ_RAISE;
      end
      if (58'sd0 < terr && terr <= tband && tq_st_ff == dtcs_pkg::TQ_LOWER) begin
         tl = dtcs_pkg::TQ_HOLD;
      end
      if (tl == 2'd3) begin
         tl = dtcs_pkg::TQ_HOLD;
      end

      // Sector edges at 60 and 120 degrees: compare y^2 against 3 x^2.
      xx3 = 37'(xx_ff) + {1'b0, xx_ff, 1'b0};
      if (b14 == 18'sd0) begin
         sec = (a14 < 18'sd0) ? 3'd3 : 3'd0;
      end else if (b14 > 18'sd0) begin
         if (a14 > 18'sd0 && 37'(yy_ff) < xx3) begin
            sec = 3'd0;
         end else if (a14 < 18'sd0 && 37'(yy_ff) <= xx3) begin
            sec = 3'd2;
         end else begin
            sec = 3'd1;
         end
      end else begin
         if (a14 < 18'sd0 && 37'(yy_ff) < xx3) begin
            sec = 3'd3;
         end else if (a14 > 18'sd0 && 37'(yy_ff) <= xx3) begin
            sec = 3'd5;
         end else begin
            sec = 3'd4;
         end
      end

      row = (flux_st_in ? 3'd3 : 3'd0) + 3'(tl);
      vec = dtcs_pkg::vec_lookup(row, sec);
      half = 15'((16'(amp_ff) + 16'd1) >> 1);
      t_shift = $signed(t36_ff[55:28]);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      tk_in        = tk_ff;
      s_in         = s_ff;
      band_in      = band_ff;
      tband_in     = tband_ff;
      high_in      = high_ff;
      t36_in       = t36_ff;
      pp_cnt_in    = pp_cnt_ff;
      pp_busy_in   = pp_busy_ff;
      tq_st_in     = tq_st_ff;
      rsp_valid_in = rsp_valid_ff;
      vec_in       = vec_ff;
      dra_in       = dra_ff;
      drb_in       = drb_ff;
      tq_in        = tq_ff;
      flux_in      = flux_ff;
      sec_in       = sec_ff;
      fl_in        = fl_ff;
      tl_in        = tl_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Pole pair scaling by shift and add, five bits.
      if (pp_busy_ff) begin
         if (pp_ff[pp_cnt_ff]) begin
            t36_in = t36_ff + (56'(s_ff) <<< pp_cnt_ff);
         end
         pp_cnt_in = pp_cnt_ff + 3'd1;
         if (pp_cnt_ff == 3'd4) begin
            pp_busy_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_M0;
            end
         end
         ST_M0: state_in = ST_M1;
         ST_M1: begin
            da_in = {{7{ua_ff[15]}}, ua_ff, 12'b0} - $signed(prod_ff[34:0]);
            state_in = ST_M2;
         end
         ST_M2: begin
            db_in = {{7{ub_ff[15]}}, ub_ff, 12'b0} - $signed(prod_ff[34:0]);
            state_in = ST_M3;
         end
         ST_M3: begin
            acc_a_in = sat_acc(acc_a_ff, prod_ff);
            state_in = ST_M4;
         end
         ST_M4: begin
            acc_b_in = sat_acc(acc_b_ff, prod_ff);
            state_in = ST_M5;
         end
         ST_M5: begin
            xx_in = prod_ff[34:0];
            state_in = ST_M6;
         end
         ST_M6: begin
            yy_in = prod_ff[34:0];
            state_in = ST_M7;
         end
         ST_M7: begin
            tk_in = $signed(prod_ff[36:0]);
            state_in = ST_M8;
         end
         ST_M8: state_in = ST_M9;
         ST_M9: begin
            s_in = (50'(tk_ff) <<< 14) + $signed(prod_ff[49:0]);
            t36_in     = '0;
            pp_cnt_in  = '0;
            pp_busy_in = 1'b1;
            state_in   = ST_M10;
         end
         ST_M10: begin
            band_in = prod_ff[39:0];
            state_in = ST_M11;
         end
         ST_M11: begin
            tband_in = $signed(prod_ff[40:0]);
            state_in = ST_M12;
         end
         ST_M12: begin
            high_in = 15'((33'(prod_ff[31:0]) + 33'd32768) >> 16);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!root_busy && !pp_busy_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               tq_st_in = tl;
               vec_in   = vec;
               sec_in   = sec;
               fl_in    = flux_st_in;
               tl_in    = tl;
               flux_in  = (root > 19'd65535) ? 16'hFFFF : root[15:0];
               if (t_shift > 28'sd32767) begin
                  tq_in = 16'sh7FFF;
               end else if (t_shift < -28'sd32768) begin
                  tq_in = -16'sh8000;
               end else begin
                  tq_in = t_shift[15:0];
               end
               case (vec)
                  dtcs_pkg::VEC_P0: begin
                     dra_in = 16'(amp_ff); drb_in = '0;
                  end
                  dtcs_pkg::VEC_P60: begin
                     dra_in = 16'(half); drb_in = 16'(high_ff);
                  end
                  dtcs_pkg::VEC_P120: begin
                     dra_in = -16'(half); drb_in = 16'(high_ff);
                  end
                  dtcs_pkg::VEC_P180: begin
                     dra_in = -16'(amp_ff); drb_in = '0;
                  end
                  dtcs_pkg::VEC_P240: begin
                     dra_in = -16'(half); drb_in = -16'(high_ff);
                  end
                  dtcs_pkg::VEC_P300: begin
                     dra_in = 16'(half); drb_in = -16'(high_ff);
                  end
                  default: begin
                     dra_in = '0; drb_in = '0;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pp_busy_ff   <= 1'b0;
         acc_a_ff     <= '0;
         acc_b_ff     <= '0;
         flux_st_ff   <= dtcs_pkg::FLUX_RAISE;
         tq_st_ff     <= dtcs_pkg::TQ_RAISE;
         res_ff       <= 16'd1843;
         per_ff       <= 24'd1678;
         fcmd_ff      <= 16'd1638;
         tcmd_ff      <= 16'sd7680;
         amp_ff       <= 15'd26;
         pp_ff        <= 5'd2;
         kemf_ff      <= 16'd8258;
         ldiff_ff     <= -16'sd13201;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pp_busy_ff   <= pp_busy_in;
         acc_a_ff     <= acc_a_in;
         acc_b_ff     <= acc_b_in;
         if (state_ff == ST_FIN && state_in == ST_IDLE) begin
            flux_st_ff <= flux_st_in;
         end
         tq_st_ff     <= tq_st_in;
         if (csr_we) begin
            case (csr_index)
               dtcs_pkg::REG_RESISTANCE: res_ff   <= csr_wdata[15:0];
               dtcs_pkg::REG_PERIOD:     per_ff   <= csr_wdata[23:0];
               dtcs_pkg::REG_FLUX_CMD:   fcmd_ff  <= csr_wdata[15:0];
               dtcs_pkg::REG_TORQUE_CMD: tcmd_ff  <= $signed(csr_wdata[15:0]);
               dtcs_pkg::REG_AMPLITUDE:  amp_ff   <= csr_wdata[14:0];
               dtcs_pkg::REG_POLE_PAIRS: pp_ff    <= csr_wdata[4:0];
               dtcs_pkg::REG_BACK_EMF:   kemf_ff  <= csr_wdata[15:0];
               dtcs_pkg::REG_L_DIFF:     ldiff_ff <= $signed(csr_wdata[15:0]);
               default: ;
            endcase
         end
      end
      if (state_ff == ST_IDLE && req_valid) begin
         ua_ff <= req_u_alpha;
         ub_ff <= req_u_beta;
         ia_ff <= req_i_alpha;
         ib_ff <= req_i_beta;
         id_ff <= req_i_d;
         iq_ff <= req_i_q;
      end
      prod_ff   <= prod_in;
      da_ff     <= da_in;
      db_ff     <= db_in;
      xx_ff     <= xx_in;
      yy_ff     <= yy_in;
      tk_ff     <= tk_in;
      s_ff      <= s_in;
      band_ff   <= band_in;
      tband_ff  <= tband_in;
      high_ff   <= high_in;
      t36_ff    <= t36_in;
      pp_cnt_ff <= pp_cnt_in;
      vec_ff    <= vec_in;
      dra_ff    <= dra_in;
      drb_ff    <= drb_in;
      tq_ff     <= tq_in;
      flux_ff   <= flux_in;
      sec_ff    <= sec_in;
      fl_ff     <= fl_in;
      tl_ff     <= tl_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vector_index    = vec_ff;
   assign rsp_drive_alpha     = dra_ff;
   assign rsp_drive_beta      = drb_ff;
   assign rsp_torque_estimate = tq_ff;
   assign rsp_flux_estimate   = flux_ff;
   assign rsp_sector          = sec_ff;
   assign rsp_flux_level      = fl_ff;
   assign rsp_torque_level    = tl_ff;

endmodule

`default_nettype wire

>>> hdl/dtcs_checker.sv
// Port-level checks of the DTC switching block, bound to the top level.
// Depends on direct_torque_control_switching_top for its port names.
`default_nettype none

module dtcs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic        [2:0]                   rsp_vector_index,
   input wire logic signed [15:0]                  rsp_drive_alpha,
   input wire logic signed [15:0]                  rsp_drive_beta,
   input wire logic signed [15:0]                  rsp_torque_estimate,
   input wire logic        [15:0]                  rsp_flux_estimate,
   input wire logic        [2:0]                   rsp_sector,
   input wire logic                                rsp_flux_level,
   input wire logic        [1:0]                   rsp_torque_level
);

   // A stalled result word stays offered with every field unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vector_index)
         && $stable(rsp_drive_alpha) && $stable(rsp_drive_beta)
         && $stable(rsp_torque_estimate) && $stable(rsp_flux_estimate)
         && $stable(rsp_sector) && $stable(rsp_flux_level)
         && $stable(rsp_torque_level))
      else $error("result word dropped while stalled");

   // One sample at a time: the block is busy right after taking a word.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second sample while busy");

   // Zero vectors drive no voltage.
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_vector_index == 3'd0 || rsp_vector_index == 3'd7)
      |-> rsp_drive_alpha == 16'sd0 && rsp_drive_beta == 16'sd0)
      else $error("zero vector with nonzero drive");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sector <= 3'd5 && rsp_torque_level != 2'd3)
      else $error("sector or torque level out of range");

endmodule

bind direct_torque_control_switching_top dtcs_checker u_dtcs_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for direct_torque_control_switching_top: a scoreboard
// predicts each result word from the accepted sample words. Depends on dtcs_pkg.
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic signed [15:0] u_alpha, u_beta, i_alpha, i_beta, i_d, i_q;
   } sample_type;

   typedef struct {
      logic [2:0]         vector_index;
      logic signed [15:0] drive_alpha, drive_beta, torque_estimate;
      logic [15:0]        flux_estimate;
      logic [2:0]         sector;
      logic               flux_level;
      logic [1:0]         torque_level;
   } switch_word_type;

   class dtc_scoreboard;
      longint resistance = 1843, period = 1678, flux_cmd = 1638, torque_cmd = 7680;
      longint amplitude = 26, pole_pairs = 2, back_emf = 8258, l_diff = -13201;
      longint flux_a = 0, flux_b = 0;
      logic flux_lvl = dtcs_pkg::FLUX_RAISE;
      logic [1:0] torque_lvl = dtcs_pkg::TQ_RAISE;
      switch_word_type expected_words[$];
      int mismatches = 0;
      int words_checked = 0;

      function void set_reg(logic [dtcs_pkg::CSR_IDX_W-1:0] idx,
                            logic [dtcs_pkg::CSR_DATA_W-1:0] v);
         case (idx)
            dtcs_pkg::REG_RESISTANCE: resistance = v[15:0];
            dtcs_pkg::REG_PERIOD:     period     = v[23:0];
            dtcs_pkg::REG_FLUX_CMD:   flux_cmd   = v[15:0];
            dtcs_pkg::REG_TORQUE_CMD: torque_cmd = longint'($signed(v[15:0]));
            dtcs_pkg::REG_AMPLITUDE:  amplitude  = v[14:0];
            dtcs_pkg::REG_POLE_PAIRS: pole_pairs = v[4:0];
            dtcs_pkg::REG_BACK_EMF:   back_emf   = v[15:0];
            dtcs_pkg::REG_L_DIFF:     l_diff     = longint'($signed(v[15:0]));
            default: ;
         endcase
      endfunction

      function longint clampl(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint integrate(longint acc, longint u, longint i);
         longint d;
         d = clampl(u * 4096 - resistance * i, -(64'sd1 <<< 38), (64'sd1 <<< 38) - 1);
         d = (d * period) >>> 16;
         return clampl(acc + d, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      endfunction

      function longint root_floor(longint v);
         longint r, b;
         r = 0;
         b = 64'sd1 <<< 62;
         while (b > v) b = b >>> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         return r;
      endfunction

      // Sector from the signs and from y^2 against 3x^2, which marks 60 degrees.
      function logic [2:0] flux_sector(longint x, longint y);
         longint yy, xx3;
         yy = y * y;
         xx3 = 3 * x * x;
         if (y == 0) return x < 0 ? 3'd3 : 3'd0;
         if (y > 0) begin
            if (x > 0 && yy < xx3) return 3'd0;
            if (x < 0 && yy <= xx3) return 3'd2;
            return 3'd1;
         end
         if (x < 0 && yy < xx3) return 3'd3;
         if (x > 0 && yy <= xx3) return 3'd5;
         return 3'd4;
      endfunction

      function void note_sample(sample_type s);
         longint id, iq, a14, b14, mag, t36, err, band, terr, tband, half, high;
         logic [1:0] tl;
         switch_word_type w;
         id = s.i_d;
         iq = s.i_q;
         flux_a = integrate(flux_a, s.u_alpha, s.i_alpha);
         flux_b = integrate(flux_b, s.u_beta, s.i_beta);
         a14 = flux_a >>> 14;
         b14 = flux_b >>> 14;
         mag = root_floor(a14 * a14 + b14 * b14);
         t36 = pole_pairs * (iq * back_emf * 16384 + l_diff * id * iq);

         err = (flux_cmd - mag) * 16777216;
         band = flux_cmd * period;
         if (err >= band) flux_lvl = dtcs_pkg::FLUX_RAISE;
         if (err <= -band) flux_lvl = dtcs_pkg::FLUX_LOWER;

         terr = torque_cmd * 268435456 - t36;
         tband = torque_cmd * period * 16;
         tl = torque_lvl;
         if (terr > tband) tl = dtcs_pkg::TQ_RAISE;
         if (terr < -tband) tl = dtcs_pkg::TQ_LOWER;
         if (terr == 0) tl = dtcs_pkg::TQ_HOLD;
         if (-tband <= terr && terr < 0 && torque_lvl == dtcs_pkg::TQ_RAISE)
            tl = dtcs_pkg::TQ_HOLD;
         if (-tband <= terr && terr < 0 && torque_lvl == dtcs_pkg::TQ_LOWER)
            tl = dtcs_pkg::TQ_LOWER;
         if (0 < terr && terr <= tband && torque_lvl == dtcs_pkg::TQ_RAISE)
            tl = dtcs_pkg::TQ_RAISE;
         if (0 < terr && terr <= tband && torque_lvl == dtcs_pkg::TQ_LOWER)
            tl = dtcs_pkg::TQ_HOLD;
         torque_lvl = tl;

         w.sector = flux_sector(a14, b14);
         w.vector_index = dtcs_pkg::VEC_TABLE[(flux_lvl == dtcs_pkg::FLUX_LOWER ? 3 : 0)
                                              + tl][w.sector];
         half = (amplitude + 1) >>> 1;
         high = (amplitude * 56756 + 32768) >>> 16;
         case (w.vector_index)
            dtcs_pkg::VEC_P0: begin
               w.drive_alpha = 16'(amplitude);  w.drive_beta = 16'sd0;
            end
            dtcs_pkg::VEC_P60: begin
               w.drive_alpha = 16'(half);       w.drive_beta = 16'(high);
            end
            dtcs_pkg::VEC_P120: begin
               w.drive_alpha = 16'(-half);      w.drive_beta = 16'(high);
            end
            dtcs_pkg::VEC_P180: begin
               w.drive_alpha = 16'(-amplitude); w.drive_beta = 16'sd0;
            end
            dtcs_pkg::VEC_P240: begin
               w.drive_alpha = 16'(-half);      w.drive_beta = 16'(-high);
            end
            dtcs_pkg::VEC_P300: begin
               w.drive_alpha = 16'(half);       w.drive_beta = 16'(-high);
            end
            default: begin
               w.drive_alpha = 16'sd0;          w.drive_beta = 16'sd0;
            end
         endcase
         w.torque_estimate = 16'(clampl(t36 >>> 28, -32768, 32767));
         w.flux_estimate = 16'(clampl(mag, 0, 65535));
         w.flux_level = flux_lvl;
         w.torque_level = tl;
         expected_words.push_back(w);
      endfunction

      function void compare(string field, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on word %0d, %s: expected %0d, got %0d",
                        words_checked, field, exp_v, act_v);
         end
      endfunction

      function void check_word(switch_word_type a);
         switch_word_type e;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result word with no sample pending");
            return;
         end
         e = expected_words.pop_front();
         compare("vector_index", e.vector_index, a.vector_index);
         compare("drive_alpha", e.drive_alpha, a.drive_alpha);
         compare("drive_beta", e.drive_beta, a.drive_beta);
         compare("torque_estimate", e.torque_estimate, a.torque_estimate);
         compare("flux_estimate", e.flux_estimate, a.flux_estimate);
         compare("sector", e.sector, a.sector);
         compare("flux_level", e.flux_level, a.flux_level);
         compare("torque_level", e.torque_level, a.torque_level);
         words_checked++;
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_u_alpha = '0, req_u_beta = '0, req_i_alpha = '0;
   logic signed [15:0] req_i_beta = '0, req_i_d = '0, req_i_q = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_vector_index, rsp_sector;
   logic signed [15:0] rsp_drive_alpha, rsp_drive_beta, rsp_torque_estimate;
   logic [15:0] rsp_flux_estimate;
   logic rsp_flux_level;
   logic [1:0] rsp_torque_level;
   logic csr_we = 1'b0;
   logic [dtcs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [dtcs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   dtc_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;
   int samples_sent = 0;

   always #6 clock = ~clock;

   direct_torque_control_switching_top dut (.*);

   // Result side: check accepted words, stall at random, watch for a hang.
   always @(posedge clock) begin
      switch_word_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            w.vector_index = rsp_vector_index;
            w.drive_alpha = rsp_drive_alpha;
            w.drive_beta = rsp_drive_beta;
            w.torque_estimate = rsp_torque_estimate;
            w.flux_estimate = rsp_flux_estimate;
            w.sector = rsp_sector;
            w.flux_level = rsp_flux_level;
            w.torque_level = rsp_torque_level;
            sb.check_word(w);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words pending", sb.expected_words.size());
            $display("CHECKS FAILED");
            $finish;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(logic [dtcs_pkg::CSR_IDX_W-1:0] idx,
                            logic [dtcs_pkg::CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic load_regs(longint r[8]);
      for (int k = 0; k < 8; k++)
         csr_write(k[dtcs_pkg::CSR_IDX_W-1:0], r[k][dtcs_pkg::CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(sample_type s);
      int gap;
      req_valid <= 1'b1;
      req_u_alpha <= s.u_alpha;
      req_u_beta <= s.u_beta;
      req_i_alpha <= s.i_alpha;
      req_i_beta <= s.i_beta;
      req_i_d <= s.i_d;
      req_i_q <= s.i_q;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_sample(s);
      samples_sent++;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_words.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_field(int kind);
      case (kind)
         0: return 16'($urandom());
         1: return 16'($signed($urandom_range(1023)) - 512);
         default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int kind;
      kind = $urandom_range(9) < 5 ? 0 : ($urandom_range(9) < 7 ? 1 : 2);
      s.u_alpha = pick_field(kind);
      s.u_beta = pick_field(kind);
      s.i_alpha = pick_field(kind);
      s.i_beta = pick_field(kind);
      s.i_d = pick_field($urandom_range(2));
      s.i_q = pick_field($urandom_range(2));
      return s;
   endfunction

   initial begin
      longint regs[8];
      sample_type s;
      int pct_send[5] = '{0, 55, 0, 21, 0};
      int pct_recv[5] = '{0, 0, 55, 21, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset settings: field extremes, each sign of each
      // axis so the flux walks through the sectors, torque saturation both ways.
      s = '{16'sh7fff, 0, 0, 0, 0, 0};                 send_sample(s);
      s = '{0, 16'sh7fff, 0, 0, 0, 0};                 send_sample(s);
      s = '{16'sh8000, 0, 0, 0, 0, 0};                 send_sample(s);
      s = '{16'sh8000, 16'sh8000, 0, 0, 0, 0};         send_sample(s);
      s = '{16'sh8000, 16'sh8000, 0, 0, 0, 0};         send_sample(s);
      s = '{16'sh7fff, 0, 0, 0, 0, 0};                 send_sample(s);
      s = '{16'sh7fff, 16'sh8000, 0, 0, 0, 0};         send_sample(s);
      s = '{0, 0, 16'sh7fff, 16'sh7fff, 0, 0};         send_sample(s);
      s = '{0, 0, 16'sh8000, 16'sh8000, 0, 0};         send_sample(s);
      s = '{0, 0, 0, 0, 16'sh7fff, 16'sh7fff};         send_sample(s);
      s = '{0, 0, 0, 0, 16'sh8000, 16'sh8000};         send_sample(s);
      s = '{0, 0, 0, 0, 16'sh7fff, 16'sh8000};         send_sample(s);
      s = '{0, 0, 0, 0, 0, 16'sh0300};                 send_sample(s);
      s = '{0, 0, 0, 0, 0, 16'sh01a0};                 send_sample(s);
      s = '{0, 0, 0, 0, 0, 16'sh0100};                 send_sample(s);
      s = '{0, 0, 0, 0, 0, 0};                         send_sample(s);
      s = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff};
      send_sample(s);
      s = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000};
      send_sample(s);
      drain();

      // A zero band: zero period makes both comparators decide on sign alone,
      // and zero torque and flux commands hit the exact-zero error cases.
      regs = '{1843, 0, 0, 0, 26, 0, 8258, -13201};
      load_regs(regs);
      s = '{0, 0, 0, 0, 0, 0};                         send_sample(s);
      s = '{0, 0, 0, 0, 0, 16'sh0100};                 send_sample(s);
      s = '{0, 0, 0, 0, 0, -16'sh0100};                send_sample(s);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: regs = '{1843, 1678, 1638, 7680, 26, 2, 8258, -13201};
            1: regs = '{$urandom_range(65535), $urandom_range(4000, 1),
                        $urandom_range(65535), $signed(16'($urandom())),
                        $urandom_range(32767), $urandom_range(16, 1),
                        $urandom_range(65535), $signed(16'($urandom()))};
            2: regs = '{65535, 16777215, 65535, 32767, 32767, 31, 65535, 32767};
            3: regs = '{0, 1, 0, -32768, 0, 1, 0, -32768};
            default: regs = '{$urandom_range(4095), $urandom_range(20000, 1),
                              $urandom_range(3000), $signed(16'($urandom())),
                              32767, 16, $urandom_range(65535), -13201};
         endcase
         load_regs(regs);
         if (ph == 4) begin
            // Indexes past the register list must leave the settings alone.
            csr_write(4'd8, 24'hffffff);
            csr_write(4'd15, 24'h000000);
            csr_we <= 1'b0;
         end
         send_idle_pct = pct_send[ph];
         recv_stall_pct = pct_recv[ph];
         for (int n = 0; n < 250; n++) begin
            if (ph == 1 && n == 120) drain();
            if (n == 125) begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            if (n == 175) begin
               send_idle_pct = pct_send[ph];
               recv_stall_pct = pct_recv[ph];
            end
            send_sample(random_sample());
         end
         drain();
      end

      $display("Covered %0d samples over reset, zero-band, random and extreme settings,",
               samples_sent);
      $display("with sender gaps and result stalls; %0d result words checked.",
               sb.words_checked);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
